>>> rtl/core/pulse_glitch_merger_defines.svh
// Assertion macros for the pulse glitch merger.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef PULSE_GLITCH_MERGER_DEFINES_SVH
`define PULSE_GLITCH_MERGER_DEFINES_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define PGM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PGM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define PGM_ASSERT_IMP(lbl, ante, cons, msg)
`define PGM_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

>>> rtl/core/pgm_pkg.sv
package pgm_pkg;

	// Width of the configuration registers and of the write data.
	localparam int CFG_W = 24;
	// Width of the register index on the configuration port.
	localparam int CFG_IDX_W = 2;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_PAUSE = 2'd1;

	// Reset value of both minimum lengths.
	localparam logic [CFG_W-1:0] MIN_LEN_RESET = 24'd20;

	// Result queue: one item can add two results, so four entries
	// keep the input side running while the output side drains.
	localparam int RQ_DEPTH = 4;
	localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
	localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

endpackage

>>> rtl/core/pulse_glitch_merger.sv
// Channel   Handshake              Payload
// input     in_valid / in_ready    is_pulse, duration, last_item
// output    out_valid / out_ready  out_is_pulse, out_duration, end_of_record
// config    cfg_we (no wait)       cfg_index, cfg_data
//
// One item is accepted per cycle while in_ready is high. An item is held in an
// input register and processed there; its results enter the queue at the edge at
// which the queue has room for two more, and from there they can leave.
// Results wait in a four-entry queue; in_ready falls while an item
// waits in the input register and fewer than two entries are free, since an
// item that ends a record can add two results.
// The asynchronous reset clears the open entry, the queue and the input
// register, and loads both minimum lengths with their default of 20.
`include "pulse_glitch_merger_defines.svh"

module pulse_glitch_merger #(
	parameter int LENGTH_WIDTH = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           is_pulse,
	input  logic [LENGTH_WIDTH-1:0]        duration,
	input  logic                           last_item,

	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           out_is_pulse,
	output logic [LENGTH_WIDTH-1:0]        out_duration,
	output logic                           end_of_record,

	input  logic                           cfg_we,
	input  logic [pgm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pgm_pkg::CFG_W-1:0]      cfg_data
);

	// Comparisons against the thresholds are made at the wider of the two widths.
	localparam int CMP_W = (LENGTH_WIDTH > pgm_pkg::CFG_W) ? LENGTH_WIDTH : pgm_pkg::CFG_W;
	// One queue entry: polarity, length and end-of-record flag.
	localparam int ENT_W = LENGTH_WIDTH + 2;

	// Configuration registers.
	logic [pgm_pkg::CFG_W-1:0] min_pulse_q;
	logic [pgm_pkg::CFG_W-1:0] min_pause_q;

	// Input register.
	logic                    valid_s1;
	logic                    pol_s1;
	logic [LENGTH_WIDTH-1:0] len_s1;
	logic                    last_s1;

	// The open entry and its flags.
	logic                    cur_pol_q;
	logic [LENGTH_WIDTH-1:0] cur_len_q;
	logic                    fix_q;
	logic                    adv_q;

	// Result queue.
	logic [ENT_W-1:0]              rq_mem_q [pgm_pkg::RQ_DEPTH];
	logic [pgm_pkg::RQ_PTR_W-1:0]  head_q;
	logic [pgm_pkg::RQ_PTR_W-1:0]  tail_q;
	logic [pgm_pkg::RQ_CNT_W-1:0]  count_q;

	// Processing of the item in the input register.
	logic                    room;
	logic                    adv_s1;
	logic                    glitch;
	logic                    merge;
	logic [LENGTH_WIDTH:0]   sum_wide;
	logic [LENGTH_WIDTH-1:0] sum_sat;
	logic                    emit_prev;
	logic                    nxt_pol;
	logic [LENGTH_WIDTH-1:0] nxt_len;
	logic                    nxt_fix;
	logic                    nxt_adv;
	logic [ENT_W-1:0]        ent_prev;
	logic [ENT_W-1:0]        ent_last;
	logic [ENT_W-1:0]        wr_ent0;
	logic [1:0]              push_cnt;
	logic                    pop;

	// Configuration writes; indexes beyond the register list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_pulse_q <= pgm_pkg::MIN_LEN_RESET;
			min_pause_q <= pgm_pkg::MIN_LEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pgm_pkg::CFG_MIN_PULSE: min_pulse_q <= cfg_data;
				pgm_pkg::CFG_MIN_PAUSE: min_pause_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The input register moves on whenever the queue can take two more
	// results, so acceptance never depends on out_ready in the same cycle.
	assign room     = count_q <= pgm_pkg::RQ_CNT_W'(pgm_pkg::RQ_DEPTH - 2);
	assign adv_s1   = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pol_s1  <= is_pulse;
			len_s1  <= duration;
			last_s1 <= last_item;
		end
	end

	// A glitch is an item shorter than the minimum for its polarity; a
	// minimum of zero therefore makes nothing of that polarity a glitch.
	always_comb begin
		if (pol_s1) begin
			glitch = CMP_W'(len_s1) < CMP_W'(min_pulse_q);
		end else begin
			glitch = CMP_W'(len_s1) < CMP_W'(min_pause_q);
		end
	end

	// While a fix is pending, an item of the open entry's polarity is folded
	// into it whatever its length.
	assign merge    = fix_q && (pol_s1 == cur_pol_q);
	assign sum_wide = {1'b0, cur_len_q} + {1'b0, len_s1};
	assign sum_sat  = sum_wide[LENGTH_WIDTH] ? {LENGTH_WIDTH{1'b1}}
	                                         : sum_wide[LENGTH_WIDTH-1:0];

	always_comb begin
		emit_prev = 1'b0;
		nxt_pol   = cur_pol_q;
		nxt_len   = cur_len_q;
		nxt_fix   = fix_q;
		nxt_adv   = adv_q;
		if (merge) begin
			nxt_len = sum_sat;
			nxt_fix = 1'b0;
		end else if (glitch) begin
			nxt_len = sum_sat;
			nxt_fix = 1'b1;
		end else begin
			// The zero-length starting pause of a record is replaced silently,
			// as long as nothing has been emitted in this record yet.
			emit_prev = cur_pol_q || (cur_len_q != '0) || adv_q;
			nxt_adv   = adv_q || emit_prev;
			nxt_fix   = 1'b0;
			nxt_pol   = pol_s1;
			nxt_len   = len_s1;
		end
	end

	// The closing result of a record is the entry as it stands after this
	// item, which also covers the empty record: a zero-length pause.
	assign ent_prev = {cur_pol_q, cur_len_q, 1'b0};
	assign ent_last = {nxt_pol, nxt_len, 1'b1};
	assign wr_ent0  = emit_prev ? ent_prev : ent_last;
	assign push_cnt = adv_s1 ? ({1'b0, emit_prev} + {1'b0, last_s1}) : 2'd0;

	// Open entry; the end of a record returns it to its reset state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_pol_q <= 1'b0;
			cur_len_q <= '0;
			fix_q     <= 1'b0;
			adv_q     <= 1'b0;
		end else if (adv_s1) begin
			if (last_s1) begin
				cur_pol_q <= 1'b0;
				cur_len_q <= '0;
				fix_q     <= 1'b0;
				adv_q     <= 1'b0;
			end else begin
				cur_pol_q <= nxt_pol;
				cur_len_q <= nxt_len;
				fix_q     <= nxt_fix;
				adv_q     <= nxt_adv;
			end
		end
	end

	// Result queue storage: up to two entries written per cycle at the tail.
	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			rq_mem_q[tail_q] <= wr_ent0;
		end
		if (push_cnt == 2'd2) begin
			rq_mem_q[tail_q + pgm_pkg::RQ_PTR_W'(1)] <= ent_last;
		end
	end

	assign pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= tail_q + pgm_pkg::RQ_PTR_W'(push_cnt);
			head_q  <= head_q + pgm_pkg::RQ_PTR_W'(pop);
			count_q <= count_q + pgm_pkg::RQ_CNT_W'(push_cnt) - pgm_pkg::RQ_CNT_W'(pop);
		end
	end

	assign out_valid     = count_q != '0;
	assign out_is_pulse  = rq_mem_q[head_q][ENT_W-1];
	assign out_duration  = rq_mem_q[head_q][LENGTH_WIDTH:1];
	assign end_of_record = rq_mem_q[head_q][0];

	// The queue never holds more than its depth.
	`PGM_ASSERT_IMP(a_rq_bound, 1'b1, count_q <= pgm_pkg::RQ_CNT_W'(pgm_pkg::RQ_DEPTH),
		"result queue overfilled")
	// An item that ends a record always leaves a result waiting.
	`PGM_ASSERT_NXT(a_last_result, adv_s1 && last_s1, count_q != '0,
		"record end produced no result")
	// After the end of a record the open entry is back at its starting state.
	`PGM_ASSERT_NXT(a_last_clear, adv_s1 && last_s1,
		!fix_q && !adv_q && !cur_pol_q && (cur_len_q == '0),
		"open entry not cleared at record end")
	// A pending fix always sits on top of a glitch that was added to the entry.
	`PGM_ASSERT_NXT(a_fix_glitch, adv_s1 && !last_s1 && !merge && glitch, fix_q,
		"glitch did not arm the pending fix")

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int LW = 24;
	localparam logic [LW-1:0] LEN_SAT = '1;

	// One cleaned entry as it leaves the block.
	typedef struct packed {
		logic          pol;
		logic [LW-1:0] len;
		logic          eor;
	} entry_t;

	// One raw duration as it enters the block.
	typedef struct packed {
		logic          pol;
		logic [LW-1:0] dur;
		logic          last;
	} duration_t;

	// A row of the directed part. Rows marked typed carry their results
	// written out by hand; the others are left to the glitch predictor.
	typedef struct packed {
		bit         typed;
		logic [1:0] count;
		duration_t  stim;
		entry_t     first;
		entry_t     second;
	} dir_row_t;

	localparam entry_t NO_ENTRY = '0;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic                          is_pulse;
	logic [LW-1:0]                 duration;
	logic                          last_item;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic                          out_is_pulse;
	logic [LW-1:0]                 out_duration;
	logic                          end_of_record;
	logic                          cfg_we;
	logic [pgm_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [pgm_pkg::CFG_W-1:0]     cfg_data;

	// Our own copy of the minimum lengths and of the open entry.
	logic [pgm_pkg::CFG_W-1:0] min_pulse_q;
	logic [pgm_pkg::CFG_W-1:0] min_pause_q;
	logic             open_pol;
	logic [LW-1:0]    open_len;
	bit               fix_armed;
	bit               emitted_once;

	// Cleaned entries that the block still owes us, oldest first.
	entry_t   entries_due[$];
	dir_row_t directed_rows[$];

	int mismatches = 0;

	// Idling control. Each side has a burst mode in which it never idles,
	// so that long stretches at full rate occur alongside the random gaps.
	bit tx_burst = 0;
	bit rx_burst = 0;
	bit rx_hold_req = 0;
	int rx_stall = 0;
	logic gen_pol = 1'b0;

	pulse_glitch_merger #(
		.LENGTH_WIDTH(LW)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.is_pulse(is_pulse),
		.duration(duration),
		.last_item(last_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_is_pulse(out_is_pulse),
		.out_duration(out_duration),
		.end_of_record(end_of_record),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// Lengths never wrap; they stick at the all-ones value.
	function automatic logic [LW-1:0] sat_sum(input logic [LW-1:0] a, input logic [LW-1:0] b);
		logic [LW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[LW] ? LEN_SAT : s[LW-1:0];
	endfunction

	// Back to the start of a record: an empty pause, nothing emitted yet.
	task automatic clear_open();
		open_pol = 1'b0;
		open_len = '0;
		fix_armed = 0;
		emitted_once = 0;
	endtask

	// Advances the open entry by one raw duration. When keep is set, the
	// entries that this item causes are queued as expected results.
	task automatic merge_predict(input duration_t d, input bit keep);
		bit is_glitch;
		is_glitch = d.pol ? (d.dur < min_pulse_q) : (d.dur < min_pause_q);
		if (fix_armed && d.pol == open_pol) begin
			// A glitch was absorbed, so the next item of the entry's own
			// polarity joins it whatever its length.
			fix_armed = 0;
			open_len = sat_sum(open_len, d.dur);
		end else if (is_glitch) begin
			fix_armed = 1;
			open_len = sat_sum(open_len, d.dur);
		end else begin
			// The empty starting pause is dropped rather than emitted, as
			// long as nothing has gone out yet in this record.
			if (open_pol || open_len != 0 || emitted_once) begin
				if (keep)
					entries_due.push_back({open_pol, open_len, 1'b0});
				emitted_once = 1;
			end
			fix_armed = 0;
			open_pol = d.pol;
			open_len = d.dur;
		end
		if (d.last) begin
			if (keep)
				entries_due.push_back({open_pol, open_len, 1'b1});
			clear_open();
		end
	endtask

	function automatic int pick_gap();
		if ($urandom_range(0, 39) == 0)
			tx_burst = !tx_burst;
		return tx_burst ? 0 : $urandom_range(0, 18);
	endfunction

	// Random durations are chosen around the threshold of their polarity,
	// so that glitches, merges and new entries all occur often. Most items
	// alternate in polarity as real pulse trains do; the rest repeat one.
	function automatic duration_t random_duration();
		duration_t d;
		logic [LW-1:0] thr;
		logic [LW:0] wide;
		int unsigned sel;
		if ($urandom_range(0, 3) != 0)
			gen_pol = !gen_pol;
		d.pol = gen_pol;
		thr = gen_pol ? min_pulse_q : min_pause_q;
		sel = $urandom_range(0, 99);
		if (sel < 20 && thr != 0) begin
			d.dur = LW'($urandom_range(0, thr - 1));
		end else if (sel < 35 && thr != 0) begin
			d.dur = LW'($urandom_range(0, (thr > 40) ? 40 : thr - 1));
		end else if (sel < 65) begin
			wide = {1'b0, thr} + (LW+1)'($urandom_range(0, 400));
			d.dur = wide[LW] ? LEN_SAT : wide[LW-1:0];
		end else if (sel < 75) begin
			// Just below, at, or just above the threshold.
			wide = {1'b0, thr} + (LW+1)'($urandom_range(0, 2));
			if (wide[LW])
				d.dur = LEN_SAT;
			else
				d.dur = (wide[LW-1:0] == 0) ? '0 : wide[LW-1:0] - 1'b1;
		end else if (sel < 85) begin
			d.dur = $urandom_range(0, 1) ? LEN_SAT : '0;
		end else begin
			d.dur = LW'($urandom());
		end
		d.last = ($urandom_range(0, 9) == 0);
		return d;
	endfunction

	// Offers one duration and returns in the time step at which it is
	// accepted. Valid is only lowered when a gap is actually drawn.
	task automatic send_duration(input duration_t d, input bit keep);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		is_pulse <= d.pol;
		duration <= d.dur;
		last_item <= d.last;
		do
			@(posedge clk);
		while (!in_ready);
		merge_predict(d, keep);
	endtask

	// Waits until every owed entry has arrived, then goes on waiting so
	// that an item which produced nothing has left the pipeline as well.
	task automatic settle();
		in_valid <= 1'b0;
		while (entries_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [pgm_pkg::CFG_IDX_W-1:0] idx,
			input logic [pgm_pkg::CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == pgm_pkg::CFG_MIN_PULSE)
			min_pulse_q = val;
		else if (idx == pgm_pkg::CFG_MIN_PAUSE)
			min_pause_q = val;
		@(posedge clk);
	endtask

	task automatic row(input bit typed, input logic [1:0] count, input logic p,
			input logic [LW-1:0] d, input logic l, input entry_t r0, input entry_t r1);
		directed_rows.push_back({typed, count, p, d, l, r0, r1});
	endtask

	// Receiving side. A result item is accepted at an edge where valid and
	// ready were both high; it is then checked against the oldest owed
	// entry, and a fresh stall is drawn. A hold request from the stimulus
	// side turns into a long stall that is counted down here.
	always @(posedge clk) begin : rx_side
		entry_t want;
		if (arst_n && out_valid && out_ready) begin
			if (entries_due.size() == 0) begin
				$error("unexpected result item: out_is_pulse %0d, out_duration %0d, end_of_record %0d",
					out_is_pulse, out_duration, end_of_record);
				mismatches++;
			end else begin
				want = entries_due.pop_front();
				if (out_is_pulse !== want.pol) begin
					$error("out_is_pulse: expected %0d, got %0d", want.pol, out_is_pulse);
					mismatches++;
				end
				if (out_duration !== want.len) begin
					$error("out_duration: expected %0d, got %0d", want.len, out_duration);
					mismatches++;
				end
				if (end_of_record !== want.eor) begin
					$error("end_of_record: expected %0d, got %0d", want.eor, end_of_record);
					mismatches++;
				end
			end
			if ($urandom_range(0, 39) == 0)
				rx_burst = !rx_burst;
			rx_stall = rx_burst ? 0 : $urandom_range(0, 18);
		end
		if (rx_hold_req) begin
			rx_hold_req = 0;
			rx_stall = 400;
		end
		if (rx_stall > 0) begin
			out_ready <= 1'b0;
			rx_stall--;
		end else
			out_ready <= 1'b1;
	end

	initial begin : stimulus
		logic [pgm_pkg::CFG_W-1:0] pulse_cfg [9];
		logic [pgm_pkg::CFG_W-1:0] pause_cfg [9];
		int phase_items [9];
		dir_row_t cur;
		int waited;

		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		is_pulse = 1'b0;
		duration = '0;
		last_item = 1'b0;
		cfg_we = 1'b0;
		cfg_index = pgm_pkg::CFG_MIN_PULSE;
		cfg_data = '0;

		min_pulse_q = pgm_pkg::MIN_LEN_RESET;
		min_pause_q = pgm_pkg::MIN_LEN_RESET;
		clear_open();

		// Settings per phase. Phase 0 runs on the reset values and is not
		// written; later phases cover zero minimums, all-ones minimums,
		// mixed extremes and random values, small and full range.
		pulse_cfg = '{pgm_pkg::MIN_LEN_RESET, 24'd0, 24'd25, LEN_SAT, 24'd0, LEN_SAT,
			24'd0, 24'd0, 24'd0};
		pause_cfg = '{pgm_pkg::MIN_LEN_RESET, 24'd0, 24'd40, LEN_SAT, LEN_SAT, 24'd0,
			24'd0, 24'd0, 24'd0};
		phase_items = '{300, 200, 300, 200, 180, 180, 200, 200, 100};
		for (int p = 6; p < 8; p++) begin
			pulse_cfg[p] = pgm_pkg::CFG_W'($urandom_range(1, 64));
			pause_cfg[p] = pgm_pkg::CFG_W'($urandom_range(1, 64));
		end
		pulse_cfg[8] = pgm_pkg::CFG_W'($urandom_range(0, 16777215));
		pause_cfg[8] = pgm_pkg::CFG_W'($urandom_range(0, 16777215));

		// Directed part, on the reset minimums of 20.
		// An empty record: a zero pause is a glitch, and the flush still
		// signals the end with an empty pause.
		row(1, 1, 1'b0, '0, 1'b1, {1'b0, 24'd0, 1'b1}, NO_ENTRY);
		// The longest pulse replaces the starting pause without emitting it.
		row(1, 0, 1'b1, LEN_SAT, 1'b0, NO_ENTRY, NO_ENTRY);
		// A short pulse on top of it saturates, and the pulse after the
		// glitch joins the entry.
		row(1, 0, 1'b1, 24'd5, 1'b0, NO_ENTRY, NO_ENTRY);
		row(1, 0, 1'b1, 24'd100, 1'b0, NO_ENTRY, NO_ENTRY);
		// The longest pause emits the pulse, then is flushed itself.
		row(1, 2, 1'b0, LEN_SAT, 1'b1, {1'b1, LEN_SAT, 1'b0}, {1'b0, LEN_SAT, 1'b1});
		// Glitches and merges of both polarities, thresholds on the edge.
		row(0, 0, 1'b0, 24'd3, 1'b0, NO_ENTRY, NO_ENTRY);
		row(0, 0, 1'b0, 24'd50, 1'b0, NO_ENTRY, NO_ENTRY);
		row(0, 0, 1'b1, 24'd30, 1'b0, NO_ENTRY, NO_ENTRY);
		row(0, 0, 1'b0, 24'd10, 1'b0, NO_ENTRY, NO_ENTRY);
		row(0, 0, 1'b0, 24'd25, 1'b0, NO_ENTRY, NO_ENTRY);
		row(0, 0, 1'b1, 24'd19, 1'b0, NO_ENTRY, NO_ENTRY);
		row(0, 0, 1'b1, 24'd20, 1'b0, NO_ENTRY, NO_ENTRY);
		row(0, 0, 1'b0, 24'd20, 1'b1, NO_ENTRY, NO_ENTRY);
		// A glitch before the first long item keeps pause polarity.
		row(1, 1, 1'b1, 24'd7, 1'b1, {1'b0, 24'd7, 1'b1}, NO_ENTRY);
		row(0, 0, 1'b0, '0, 1'b0, NO_ENTRY, NO_ENTRY);
		row(0, 0, 1'b1, 24'd40, 1'b0, NO_ENTRY, NO_ENTRY);
		row(0, 0, 1'b1, 24'd40, 1'b1, NO_ENTRY, NO_ENTRY);
		// A record of one long pause.
		row(1, 1, 1'b0, 24'd25, 1'b1, {1'b0, 24'd25, 1'b1}, NO_ENTRY);
		// A sum that overflows sticks at the maximum.
		row(1, 0, 1'b1, 24'hFFFFF0, 1'b0, NO_ENTRY, NO_ENTRY);
		row(1, 0, 1'b1, 24'h000010, 1'b0, NO_ENTRY, NO_ENTRY);
		row(1, 1, 1'b1, '0, 1'b1, {1'b1, LEN_SAT, 1'b1}, NO_ENTRY);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (directed_rows[i]) begin
			cur = directed_rows[i];
			send_duration(cur.stim, !cur.typed);
			if (cur.typed) begin
				if (cur.count > 0)
					entries_due.push_back(cur.first);
				if (cur.count > 1)
					entries_due.push_back(cur.second);
			end
		end

		for (int p = 0; p < 9; p++) begin
			if (p > 0) begin
				settle();
				write_reg(pgm_pkg::CFG_MIN_PULSE, pulse_cfg[p]);
				write_reg(pgm_pkg::CFG_MIN_PAUSE, pause_cfg[p]);
			end
			if (p == 2) begin
				// The receiver stops for a long while as the sender keeps
				// offering at full rate, so the result queue fills and the
				// block has to hold off its input.
				tx_burst = 1;
				rx_hold_req = 1;
			end
			repeat (phase_items[p])
				send_duration(random_duration(), 1);
		end

		in_valid <= 1'b0;
		waited = 0;
		while (entries_due.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (entries_due.size() != 0)
			$error("%0d expected result items never arrived", entries_due.size());
		if (mismatches == 0 && entries_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog: several times the slowest legal run.
	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

>>> pulse_glitch_merger.f
+incdir+rtl/core
rtl/core/pgm_pkg.sv
rtl/core/pulse_glitch_merger.sv
sim/testbench.sv
